[hw/rtl/nmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmc_pkg
// Shared constants, codes and types of the neighbourhood mean cosine unit.
// ----------------------------------------------------------------------------
package nmc_pkg;

  localparam int MAX_X      = 16;
  localparam int MAX_Y      = 16;
  localparam int MAX_Z      = 16;
  localparam int MAX_T      = 4;
  localparam int MAX_RADIUS = 3;

  localparam int X_W     = $clog2(MAX_X);
  localparam int Y_W     = $clog2(MAX_Y);
  localparam int Z_W     = $clog2(MAX_Z);
  localparam int T_W     = $clog2(MAX_T);
  localparam int ADDR_W  = X_W + Y_W + Z_W + T_W;
  localparam int DEPTH   = MAX_X * MAX_Y * MAX_Z * MAX_T;
  localparam int VEL_W   = 16;
  localparam int SPD_W   = 24;
  localparam int WORD_W  = 3 * VEL_W + SPD_W;
  localparam int CNT_W   = 12;
  localparam int SUM_W   = 28;
  localparam int DOT_W   = 34;
  localparam int DEN_W   = 2 * SPD_W;
  localparam int RAD_W   = 48;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_SIZE_T,
    REG_RADIUS_X, REG_RADIUS_Y, REG_RADIUS_Z, REG_RADIUS_T
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQMUL, S_SQSTART, S_SQWAIT, S_STWR, S_WIN, S_CEN, S_NBRD,
    S_NBMUL, S_NBDOT, S_DSTART, S_DWAIT, S_ADV, S_MSTART, S_MWAIT, S_OUT
  } state_t;

endpackage

[hw/rtl/nmc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmc_if
// Valid/ready channels of the neighbourhood mean cosine unit.
// ----------------------------------------------------------------------------
interface nmc_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [3:0]         pos_x;
  logic [3:0]         pos_y;
  logic [3:0]         pos_z;
  logic [1:0]         pos_t;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;

  modport source(output valid, func, pos_x, pos_y, pos_z, pos_t, vel_x, vel_y, vel_z,
                 input ready);
  modport sink(input valid, func, pos_x, pos_y, pos_z, pos_t, vel_x, vel_y, vel_z,
               output ready);
endinterface

interface nmc_out_if;
  logic               valid;
  logic               ready;
  logic               is_query;
  logic signed [15:0] mean_cosine;
  logic [11:0]        neighbour_count;

  modport source(output valid, is_query, mean_cosine, neighbour_count, input ready);
  modport sink(input valid, is_query, mean_cosine, neighbour_count, output ready);
endinterface

[hw/rtl/nmc_vol_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmc_vol_mem
// Voxel memory: velocity and speed per entry, one write and one read port.
// ----------------------------------------------------------------------------
module nmc_vol_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [nmc_pkg::ADDR_W-1:0] wa,
  input  logic [nmc_pkg::WORD_W-1:0] wd,
  input  logic [nmc_pkg::ADDR_W-1:0] ra,
  output logic [nmc_pkg::WORD_W-1:0] rd
);

  logic [nmc_pkg::WORD_W-1:0] mem [nmc_pkg::DEPTH];
  logic [nmc_pkg::WORD_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

[hw/rtl/nmc_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmc_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module nmc_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [nmc_pkg::RAD_W-1:0] rad,
  output logic                      done,
  output logic [nmc_pkg::SPD_W-1:0] root
);

  logic                      busy_r;
  logic                      done_r;
  logic [4:0]                step_r;
  logic [nmc_pkg::RAD_W-1:0] rad_r;
  logic [26:0]               rem_r;
  logic [nmc_pkg::SPD_W-1:0] root_r;
  logic [26:0]               rem_t;
  logic [26:0]               trial;

  assign rem_t = {rem_r[24:0], rad_r[nmc_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
      step_r <= 5'(nmc_pkg::SPD_W - 1);
    end else if (busy_r) begin
      rad_r  <= {rad_r[nmc_pkg::RAD_W-3:0], 2'b00};
      step_r <= step_r - 5'd1;
      if (rem_t >= trial) begin
        rem_r  <= rem_t - trial;
        root_r <= {root_r[nmc_pkg::SPD_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_t;
        root_r <= {root_r[nmc_pkg::SPD_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[hw/rtl/nmc_cos_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmc_cos_div
// Cosine divider: dot * 2^31 / den, truncated and saturated to Q1.15.
// ----------------------------------------------------------------------------
module nmc_cos_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [nmc_pkg::DOT_W-1:0] dot,
  input  logic [nmc_pkg::DEN_W-1:0]        den,
  output logic                             done,
  output logic signed [15:0]               cos
);

  logic                      busy_r;
  logic                      done_r;
  logic [4:0]                step_r;
  logic [63:0]               rem_r;
  logic [63:0]               dv_r;
  logic [16:0]               q_r;
  logic                      neg_r;
  logic signed [15:0]        cos_r;
  logic [nmc_pkg::DOT_W-1:0] mag;
  logic                      ge;
  logic [16:0]               q_nxt;
  logic signed [15:0]        sat;

  assign mag   = dot[nmc_pkg::DOT_W-1] ? nmc_pkg::DOT_W'(-dot) : nmc_pkg::DOT_W'(dot);
  assign ge    = rem_r >= dv_r;
  assign q_nxt = {q_r[15:0], ge};

  always_comb begin
    if (neg_r) begin
      sat = (q_nxt > 17'd32768) ? 16'sh8000 : 16'(~q_nxt[15:0] + 16'd1);
    end else begin
      sat = (q_nxt > 17'd32767) ? 16'sh7fff : q_nxt[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !(dot == '0 || den == '0);
        done_r <= (dot == '0 || den == '0);
      end else if (busy_r && step_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dot[nmc_pkg::DOT_W-1];
      rem_r  <= {1'b0, mag[31:0], 31'b0};
      dv_r   <= {den, 16'b0};
      q_r    <= '0;
      step_r <= 5'd16;
      cos_r  <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dv_r;
      end
      dv_r   <= {1'b0, dv_r[63:1]};
      q_r    <= q_nxt;
      step_r <= step_r - 5'd1;
      if (step_r == 5'd0) begin
        cos_r <= sat;
      end
    end
  end

  assign done = done_r;
  assign cos  = cos_r;

endmodule

[hw/rtl/nmc_mean_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmc_mean_div
// Mean divider: signed sum over count, truncated toward zero.
// ----------------------------------------------------------------------------
module nmc_mean_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [nmc_pkg::SUM_W-1:0] sum,
  input  logic [nmc_pkg::CNT_W-1:0]        cnt,
  output logic                             done,
  output logic signed [15:0]               mean
);

  localparam int QW = nmc_pkg::SUM_W - 1;
  localparam int RW = QW + nmc_pkg::CNT_W - 1;

  logic                      busy_r;
  logic                      done_r;
  logic [4:0]                step_r;
  logic [RW-1:0]             rem_r;
  logic [RW-1:0]             dv_r;
  logic [QW-1:0]             q_r;
  logic                      neg_r;
  logic [nmc_pkg::SUM_W-1:0] mag;
  logic                      ge;

  assign mag = sum[nmc_pkg::SUM_W-1] ? nmc_pkg::SUM_W'(-sum) : nmc_pkg::SUM_W'(sum);
  assign ge  = rem_r >= dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= sum[nmc_pkg::SUM_W-1];
      rem_r  <= RW'(mag[QW-1:0]);
      dv_r   <= {cnt, {(QW-1){1'b0}}};
      q_r    <= '0;
      step_r <= 5'(QW - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dv_r;
      end
      dv_r   <= {1'b0, dv_r[RW-1:1]};
      q_r    <= {q_r[QW-2:0], ge};
      step_r <= step_r - 5'd1;
    end
  end

  assign done = done_r;
  assign mean = neg_r ? 16'(~q_r[15:0] + 16'd1) : q_r[15:0];

endmodule

[hw/rtl/neighbourhood_mean_cosine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbourhood_mean_cosine_unit
// Stores voxel velocities of a 4D volume and answers mean cosine queries.
// ----------------------------------------------------------------------------
// Input channel in_ch carries one word per item: a store (func 0) writes a
// voxel's velocity and its Q16.8 speed; a query (func 1) walks the clipped
// window around a voxel. Output channel out_ch returns one word per item:
// a store acknowledge, or the mean Q1.15 cosine and the neighbour count.
// The APB port sets grid sizes and radii; write it only while idle.
// A store runs the 24-step square root, then one memory write. A query
// does per neighbour one memory read, products and a 17-step divide, the
// divide cut short when the dot product is zero, and ends with the mean
// divide. The largest window is 7x7x7x4. Items outside the grid go
// straight to the output state.
// One item is worked on at a time; the next is taken in the cycle after
// the current result is loaded into the output register.
// Reset idles the state machine, sets default sizes and radii, clears the
// output register; memory stays undefined until written. A stalled receiver
// holds the result word and blocks completion of the next item until taken.
// ----------------------------------------------------------------------------
module neighbourhood_mean_cosine_unit (
  input  logic              clk,
  input  logic              rst_n,
  nmc_in_if.sink            in_ch,
  nmc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  nmc_pkg::state_t state_r, state_nxt;

  logic [4:0] size_x_r, size_y_r, size_z_r;
  logic [2:0] size_t_r;
  logic [1:0] rad_x_r, rad_y_r, rad_z_r, rad_t_r;

  logic                      func_r;
  logic [3:0]                px_r, py_r, pz_r;
  logic [1:0]                pt_r;
  logic signed [15:0]        vx_r, vy_r, vz_r;
  logic signed [15:0]        cvx_r, cvy_r, cvz_r;
  logic [nmc_pkg::SPD_W-1:0] cspd_r, nspd_r;
  logic signed [31:0]        p0_r, p1_r, p2_r;
  logic signed [nmc_pkg::DOT_W-1:0] dot_r;
  logic [nmc_pkg::DEN_W-1:0] den_r;
  logic signed [nmc_pkg::SUM_W-1:0] sum_r;
  logic [nmc_pkg::CNT_W-1:0] cnt_r;
  logic [4:0] lx_r, hx_r, ly_r, hy_r, lz_r, hz_r, ht_r;
  logic [4:0] jx_r, jy_r, jz_r, jt_r;
  logic                      res_q_r;
  logic signed [15:0]        res_mean_r;
  logic [nmc_pkg::CNT_W-1:0] res_cnt_r;
  logic                      out_valid_r, out_q_r;
  logic signed [15:0]        out_mean_r;
  logic [nmc_pkg::CNT_W-1:0] out_cnt_r;

  logic [4:0] nx, ny, nz, nt;
  logic [4:0] wlx, whx, wly, why, wlz, whz, wlt, wht;
  logic       in_acc, inside_in, out_free, last;
  logic       cfg_wr;
  logic       mem_we;
  logic [nmc_pkg::ADDR_W-1:0] mem_wa, mem_ra;
  logic [nmc_pkg::WORD_W-1:0] mem_wd, mem_rd;
  logic signed [15:0] ma0, ma1, ma2, mb0, mb1, mb2;
  logic       sq_start, sq_done, cd_start, cd_done, md_start, md_done;
  logic [nmc_pkg::SPD_W-1:0] sq_root;
  logic signed [15:0] cd_cos, md_mean;
  logic [31:0] sqsum;

  function automatic logic [4:0] clamp_size(input logic [4:0] v, input logic [4:0] m);
    logic [4:0] r;
    begin
      r = (v == 5'd0) ? 5'd1 : ((v > m) ? m : v);
      return r;
    end
  endfunction

  function automatic logic [4:0] win_lo(input logic [4:0] p, input logic [1:0] r);
    logic [4:0] re;
    begin
      re = {3'b0, r};
      return (p < re) ? 5'd0 : p - re;
    end
  endfunction

  function automatic logic [4:0] win_hi(input logic [4:0] p, input logic [1:0] r,
                                        input logic [4:0] n);
    logic [4:0] e;
    begin
      e = p + {3'b0, r} + 5'd1;
      return (e < n) ? e : n;
    end
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 5'd16;
      size_y_r <= 5'd16;
      size_z_r <= 5'd16;
      size_t_r <= 3'd4;
      rad_x_r  <= 2'd2;
      rad_y_r  <= 2'd2;
      rad_z_r  <= 2'd2;
      rad_t_r  <= 2'd1;
    end else if (cfg_wr) begin
      case (nmc_pkg::reg_idx_t'(paddr[4:2]))
        nmc_pkg::REG_SIZE_X:   size_x_r <= pwdata[4:0];
        nmc_pkg::REG_SIZE_Y:   size_y_r <= pwdata[4:0];
        nmc_pkg::REG_SIZE_Z:   size_z_r <= pwdata[4:0];
        nmc_pkg::REG_SIZE_T:   size_t_r <= pwdata[2:0];
        nmc_pkg::REG_RADIUS_X: rad_x_r  <= pwdata[1:0];
        nmc_pkg::REG_RADIUS_Y: rad_y_r  <= pwdata[1:0];
        nmc_pkg::REG_RADIUS_Z: rad_z_r  <= pwdata[1:0];
        nmc_pkg::REG_RADIUS_T: rad_t_r  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (nmc_pkg::reg_idx_t'(paddr[4:2]))
      nmc_pkg::REG_SIZE_X:   prdata = {27'b0, size_x_r};
      nmc_pkg::REG_SIZE_Y:   prdata = {27'b0, size_y_r};
      nmc_pkg::REG_SIZE_Z:   prdata = {27'b0, size_z_r};
      nmc_pkg::REG_SIZE_T:   prdata = {29'b0, size_t_r};
      nmc_pkg::REG_RADIUS_X: prdata = {30'b0, rad_x_r};
      nmc_pkg::REG_RADIUS_Y: prdata = {30'b0, rad_y_r};
      nmc_pkg::REG_RADIUS_Z: prdata = {30'b0, rad_z_r};
      nmc_pkg::REG_RADIUS_T: prdata = {30'b0, rad_t_r};
      default:               prdata = '0;
    endcase
  end

  // grid and window
  assign nx = clamp_size(size_x_r, 5'(nmc_pkg::MAX_X));
  assign ny = clamp_size(size_y_r, 5'(nmc_pkg::MAX_Y));
  assign nz = clamp_size(size_z_r, 5'(nmc_pkg::MAX_Z));
  assign nt = clamp_size({2'b0, size_t_r}, 5'(nmc_pkg::MAX_T));

  assign inside_in = ({1'b0, in_ch.pos_x} < nx) && ({1'b0, in_ch.pos_y} < ny) &&
                     ({1'b0, in_ch.pos_z} < nz) && ({3'b0, in_ch.pos_t} < nt);

  assign wlx = win_lo({1'b0, px_r}, rad_x_r);
  assign wly = win_lo({1'b0, py_r}, rad_y_r);
  assign wlz = win_lo({1'b0, pz_r}, rad_z_r);
  assign wlt = win_lo({3'b0, pt_r}, rad_t_r);
  assign whx = win_hi({1'b0, px_r}, rad_x_r, nx);
  assign why = win_hi({1'b0, py_r}, rad_y_r, ny);
  assign whz = win_hi({1'b0, pz_r}, rad_z_r, nz);
  assign wht = win_hi({3'b0, pt_r}, rad_t_r, nt);

  assign last = (jx_r + 5'd1 == hx_r) && (jy_r + 5'd1 == hy_r) &&
                (jz_r + 5'd1 == hz_r) && (jt_r + 5'd1 == ht_r);

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nmc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (!inside_in) state_nxt = nmc_pkg::S_OUT;
          else if (in_ch.func == nmc_pkg::FUNC_STORE) state_nxt = nmc_pkg::S_SQMUL;
          else state_nxt = nmc_pkg::S_WIN;
        end
      end
      nmc_pkg::S_SQMUL:   state_nxt = nmc_pkg::S_SQSTART;
      nmc_pkg::S_SQSTART: state_nxt = nmc_pkg::S_SQWAIT;
      nmc_pkg::S_SQWAIT:  if (sq_done) state_nxt = nmc_pkg::S_STWR;
      nmc_pkg::S_STWR:    state_nxt = nmc_pkg::S_OUT;
      nmc_pkg::S_WIN:     state_nxt = nmc_pkg::S_CEN;
      nmc_pkg::S_CEN:     state_nxt = nmc_pkg::S_NBRD;
      nmc_pkg::S_NBRD:    state_nxt = nmc_pkg::S_NBMUL;
      nmc_pkg::S_NBMUL:   state_nxt = nmc_pkg::S_NBDOT;
      nmc_pkg::S_NBDOT:   state_nxt = nmc_pkg::S_DSTART;
      nmc_pkg::S_DSTART:  state_nxt = nmc_pkg::S_DWAIT;
      nmc_pkg::S_DWAIT:   if (cd_done) state_nxt = nmc_pkg::S_ADV;
      nmc_pkg::S_ADV:     state_nxt = last ? nmc_pkg::S_MSTART : nmc_pkg::S_NBRD;
      nmc_pkg::S_MSTART:  state_nxt = nmc_pkg::S_MWAIT;
      nmc_pkg::S_MWAIT:   if (md_done) state_nxt = nmc_pkg::S_OUT;
      nmc_pkg::S_OUT:     if (out_free) state_nxt = nmc_pkg::S_IDLE;
      default:            state_nxt = nmc_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    sq_start    = 1'b0;
    cd_start    = 1'b0;
    md_start    = 1'b0;
    mem_ra      = {jt_r[1:0], jz_r[3:0], jy_r[3:0], jx_r[3:0]};
    case (state_r)
      nmc_pkg::S_IDLE:    in_ch.ready = 1'b1;
      nmc_pkg::S_SQSTART: sq_start    = 1'b1;
      nmc_pkg::S_STWR:    mem_we      = 1'b1;
      nmc_pkg::S_WIN:     mem_ra      = {pt_r, pz_r, py_r, px_r};
      nmc_pkg::S_DSTART:  cd_start    = 1'b1;
      nmc_pkg::S_MSTART:  md_start    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nmc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // memory
  assign mem_wa = {pt_r, pz_r, py_r, px_r};
  assign mem_wd = {vx_r, vy_r, vz_r, sq_root};

  nmc_vol_mem u_mem (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .ra  (mem_ra),
    .rd  (mem_rd)
  );

  // shared multipliers: squares on store, dot terms on query
  always_comb begin
    if (state_r == nmc_pkg::S_SQMUL) begin
      ma0 = vx_r; ma1 = vy_r; ma2 = vz_r;
      mb0 = vx_r; mb1 = vy_r; mb2 = vz_r;
    end else begin
      ma0 = cvx_r; ma1 = cvy_r; ma2 = cvz_r;
      mb0 = mem_rd[71:56]; mb1 = mem_rd[55:40]; mb2 = mem_rd[39:24];
    end
  end

  assign sqsum = 32'(p0_r) + 32'(p1_r) + 32'(p2_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r     <= in_ch.func;
      px_r       <= in_ch.pos_x;
      py_r       <= in_ch.pos_y;
      pz_r       <= in_ch.pos_z;
      pt_r       <= in_ch.pos_t;
      vx_r       <= in_ch.vel_x;
      vy_r       <= in_ch.vel_y;
      vz_r       <= in_ch.vel_z;
      res_q_r    <= in_ch.func;
      res_mean_r <= '0;
      res_cnt_r  <= '0;
    end
    if (state_r == nmc_pkg::S_SQMUL || state_r == nmc_pkg::S_NBMUL) begin
      p0_r <= ma0 * mb0;
      p1_r <= ma1 * mb1;
      p2_r <= ma2 * mb2;
    end
    if (state_r == nmc_pkg::S_NBMUL) begin
      nspd_r <= mem_rd[nmc_pkg::SPD_W-1:0];
    end
    if (state_r == nmc_pkg::S_NBDOT) begin
      dot_r <= nmc_pkg::DOT_W'(p0_r) + nmc_pkg::DOT_W'(p1_r) + nmc_pkg::DOT_W'(p2_r);
      den_r <= cspd_r * nspd_r;
    end
    if (state_r == nmc_pkg::S_WIN) begin
      lx_r <= wlx; hx_r <= whx; jx_r <= wlx;
      ly_r <= wly; hy_r <= why; jy_r <= wly;
      lz_r <= wlz; hz_r <= whz; jz_r <= wlz;
      ht_r <= wht; jt_r <= wlt;
      sum_r <= '0;
      cnt_r <= '0;
    end
    if (state_r == nmc_pkg::S_CEN) begin
      cvx_r  <= mem_rd[71:56];
      cvy_r  <= mem_rd[55:40];
      cvz_r  <= mem_rd[39:24];
      cspd_r <= mem_rd[nmc_pkg::SPD_W-1:0];
    end
    if (state_r == nmc_pkg::S_ADV) begin
      sum_r <= sum_r + nmc_pkg::SUM_W'(cd_cos);
      cnt_r <= cnt_r + 12'd1;
      if (jx_r + 5'd1 != hx_r) begin
        jx_r <= jx_r + 5'd1;
      end else begin
        jx_r <= lx_r;
        if (jy_r + 5'd1 != hy_r) begin
          jy_r <= jy_r + 5'd1;
        end else begin
          jy_r <= ly_r;
          if (jz_r + 5'd1 != hz_r) begin
            jz_r <= jz_r + 5'd1;
          end else begin
            jz_r <= lz_r;
            jt_r <= jt_r + 5'd1;
          end
        end
      end
    end
    if (state_r == nmc_pkg::S_MWAIT && md_done) begin
      res_mean_r <= md_mean;
      res_cnt_r  <= cnt_r;
    end
  end

  nmc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   ({sqsum, 16'b0}),
    .done  (sq_done),
    .root  (sq_root)
  );

  nmc_cos_div u_cos_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cd_start),
    .dot   (dot_r),
    .den   (den_r),
    .done  (cd_done),
    .cos   (cd_cos)
  );

  nmc_mean_div u_mean_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .sum   (sum_r),
    .cnt   (cnt_r),
    .done  (md_done),
    .mean  (md_mean)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_q_r     <= 1'b0;
      out_mean_r  <= '0;
      out_cnt_r   <= '0;
    end else if (state_r == nmc_pkg::S_OUT && out_free) begin
      out_valid_r <= 1'b1;
      out_q_r     <= res_q_r;
      out_mean_r  <= res_mean_r;
      out_cnt_r   <= res_cnt_r;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.is_query        = out_q_r;
  assign out_ch.mean_cosine     = out_mean_r;
  assign out_ch.neighbour_count = out_cnt_r;

`ifndef SYNTHESIS
  a_we_store: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> func_r == nmc_pkg::FUNC_STORE)
    else $error("memory write outside a store");

  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != nmc_pkg::S_IDLE)
    else $error("accepted word left block idle");

  a_cd_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cd_done |-> state_r == nmc_pkg::S_DWAIT)
    else $error("cosine divider finished out of turn");

  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_q_r) |-> (out_mean_r == '0 && out_cnt_r == '0))
    else $error("store acknowledge carries data");
`endif

endmodule
